### sv/assert_macros.svh
// Assertion macros for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/fla_pkg.sv
package fla_pkg;

	localparam int MaxBlocksDef = 64;
	localparam int HeapBytesDef = 1048576;
	localparam int HeaderBytesDef = 64;
	localparam int ChunkBytesDef = 16384;

	localparam int AddrW = 20;
	localparam int SizeW = 21;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NULL = 3'd1,
		ST_OOM = 3'd2,
		ST_INVALID = 3'd3,
		ST_DOUBLE = 3'd4,
		ST_FULL = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIT,
		S_APPLY,
		S_GROW,
		S_FIND,
		S_FREE,
		S_RIGHT,
		S_RMERGE,
		S_LEFT,
		S_LMERGE,
		S_DONE
	} state_t;

endpackage

### sv/free_list_heap_allocator.sv
// Channel  Dir  Bits  Content
// s_axis   in   48+1  tdata: request_bytes[20:0], user_address[40:21]; tuser: operation
// m_axis   out  88    tdata: status, result_address, block_bytes, bytes_in_use, peak_bytes
// cfg      in   1     search_mode
// One table entry is examined per cycle in each table scan.
// An allocate runs a fit scan with the slot scan merged in, then apply and done, with a
// grow step after apply when no free block fits.
// A release runs a lookup scan, then right and left neighbour scans for a valid live block.
// Reset clears the valid and free bits, heap top and usage totals; no clearing pass.
// s_tready is high only in the idle state, entered on the edge that loads each result.
// A result waits in the output register while the next item is worked; a finished
// item holds in the done state until that register is free.
`include "assert_macros.svh"
module free_list_heap_allocator
	import fla_pkg::*;
#(
	parameter int MAX_BLOCKS = MaxBlocksDef,
	parameter int HEAP_BYTES = HeapBytesDef,
	parameter int HEADER_BYTES = HeaderBytesDef,
	parameter int CHUNK_BYTES = ChunkBytesDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// request_bytes [20:0], user_address [40:21], zero fill to 48 bits
	input  logic [47:0]  s_tdata,
	// operation
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status [2:0], result_address [22:3], block_bytes [43:23],
	// bytes_in_use [64:44], peak_bytes [85:65], zero fill to 88 bits
	output logic [87:0]  m_tdata,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	localparam int IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CntW = $clog2(MAX_BLOCKS + 1);
	localparam int WW = 32;
	localparam logic [WW-1:0] Hdr = WW'(HEADER_BYTES);
	localparam logic [WW-1:0] MinBlk = WW'(((HEADER_BYTES + 32 + 15) / 16) * 16);
	localparam logic [WW-1:0] ChunkMask = WW'(CHUNK_BYTES - 1);
	localparam logic [WW-1:0] HeapLim = WW'(HEAP_BYTES);
	localparam logic [CntW-1:0] LastIdx = CntW'(MAX_BLOCKS - 1);

	// Block table memory and per-entry flags.
	logic [WW-1:0] start_mem [MAX_BLOCKS];
	logic [WW-1:0] size_mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] valid_q, free_q;

	state_t state_q, state_d;
	logic search_mode_q;
	logic [WW-1:0] ua_q, need_q;
	logic [CntW-1:0] idx_q;
	logic [IdxW-1:0] pick_q, slot_q, k_q, nb_q;
	logic pick_ok_q, slot_ok_q;
	logic [WW-1:0] pick_start_q, pick_size_q;
	logic [WW-1:0] k_start_q, k_size_q, nb_size_q;
	logic [WW-1:0] heap_top_q, in_use_q, peak_q;
	logic [2:0] st_q;
	logic [WW-1:0] addr_q, bytes_q;
	logic m_valid_q;
	logic [87:0] m_data_q;
	logic [WW-1:0] rd_start_s1, rd_size_s1;

	logic [IdxW-1:0] cur;
	logic scan_last;
	assign cur = idx_q[IdxW-1:0];
	assign scan_last = (idx_q == LastIdx);

	// Registered table read at the scan index.
	always_ff @(posedge clk) begin
		rd_start_s1 <= start_mem[cur];
		rd_size_s1 <= size_mem[cur];
	end

	// Entry flags of the row whose read data is current.
	logic [IdxW-1:0] rd_idx_q;
	logic rd_valid, rd_free;
	always_ff @(posedge clk) begin
		rd_idx_q <= cur;
	end
	assign rd_valid = valid_q[rd_idx_q];
	assign rd_free = free_q[rd_idx_q];

	// Shared compare unit: one entry against the current candidate.
	logic fits, better;
	always_comb begin
		fits = rd_valid && rd_free && (rd_size_s1 >= need_q);
		if (!pick_ok_q) begin
			better = 1'b1;
		end else if (search_mode_q) begin
			better = rd_start_s1 < pick_start_q;
		end else begin
			better = (rd_size_s1 < pick_size_q) ||
				((rd_size_s1 == pick_size_q) && (rd_start_s1 < pick_start_q));
		end
	end

	logic [WW-1:0] need_c, grow_c;
	always_comb begin
		need_c = ({11'd0, s_tdata[20:0]} + Hdr + 32'd15) & ~32'd15;
		if (need_c < MinBlk) need_c = MinBlk;
		grow_c = (need_q + ChunkMask) & ~ChunkMask;
	end

	// Split and growth decisions for the table writes; the split decision also drives the flag updates.
	logic split_c, grow_ok_c;
	assign split_c = pick_ok_q && (pick_size_q - need_q >= MinBlk) && slot_ok_q;
	assign grow_ok_c = !(heap_top_q + grow_c > HeapLim) && slot_ok_q;

	// In the done state the result register loads when it is empty or its beat leaves this cycle.
	logic done_load;
	logic [WW-1:0] peak_n;
	assign done_load = (state_q == S_DONE) && (!m_valid_q || m_tready);
	assign peak_n = (in_use_q > peak_q) ? in_use_q : peak_q;

	logic s_fire, m_fire;
	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	// The scan compares entry idx-1 since the read is registered; the first cycle of
	// a scan phase only primes the read.
	logic prime_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic scan_end;
	assign scan_end = !prime_q && (rd_idx_q == IdxW'(MAX_BLOCKS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_fire) begin
				if (s_tuser == OP_ALLOC) begin
					state_d = (s_tdata[20:0] == 21'd0) ? S_DONE : S_FIT;
				end else begin
					state_d = (s_tdata[40:21] == 20'd0) ? S_DONE : S_FIND;
				end
			end
			S_FIT: if (scan_end) state_d = S_APPLY;
			S_APPLY: state_d = pick_ok_q ? S_DONE : S_GROW;
			S_GROW: state_d = S_DONE;
			S_FIND: if (scan_end || (!prime_q && rd_valid && rd_start_s1 + Hdr == ua_q))
				state_d = S_FREE;
			S_FREE: state_d = (pick_ok_q && !free_q[k_q]) ? S_RIGHT : S_DONE;
			S_RIGHT: if (scan_end || (!prime_q && pick_ok_q)) state_d = S_RMERGE;
			S_RMERGE: state_d = S_LEFT;
			S_LEFT: if (scan_end || (!prime_q && pick_ok_q)) state_d = S_LMERGE;
			S_LMERGE: state_d = S_DONE;
			S_DONE: state_d = done_load ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	logic nb_hit;
	always_comb begin
		if (state_q == S_RIGHT) begin
			nb_hit = rd_valid && rd_free && (rd_idx_q != k_q) &&
				(rd_start_s1 == k_start_q + k_size_q);
		end else begin
			nb_hit = rd_valid && rd_free && (rd_idx_q != k_q) &&
				(rd_start_s1 + rd_size_s1 == k_start_q);
		end
	end

	// Table memory writes: split, growth and merge sizes.
	always_ff @(posedge clk) begin
		case (state_q)
			S_APPLY: if (split_c) begin
				start_mem[slot_q] <= pick_start_q + need_q;
				size_mem[slot_q] <= pick_size_q - need_q;
				size_mem[pick_q] <= need_q;
			end
			S_GROW: if (grow_ok_c) begin
				start_mem[slot_q] <= heap_top_q;
				size_mem[slot_q] <= grow_c;
			end
			S_RMERGE: if (pick_ok_q) size_mem[k_q] <= k_size_q + nb_size_q;
			S_LMERGE: if (pick_ok_q) size_mem[nb_q] <= nb_size_q + k_size_q;
			default: ;
		endcase
	end

	// Datapath and flag updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			free_q <= '0;
			heap_top_q <= '0;
			in_use_q <= '0;
			peak_q <= '0;
			search_mode_q <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
			idx_q <= '0;
			prime_q <= 1'b0;
			pick_ok_q <= 1'b0;
			slot_ok_q <= 1'b0;
		end else begin
			if (cfg_we) search_mode_q <= cfg_wdata;
			if (done_load) m_valid_q <= 1'b1;
			else if (m_fire) m_valid_q <= 1'b0;
			if (state_q != S_IDLE && state_q != S_DONE &&
				state_q != S_FREE && state_q != S_RMERGE) begin
				prime_q <= 1'b0;
				if (!scan_last) idx_q <= idx_q + 1'b1;
			end
			case (state_q)
				S_IDLE: if (s_fire) begin
					ua_q <= {12'd0, s_tdata[40:21]};
					need_q <= need_c;
					idx_q <= '0;
					prime_q <= 1'b1;
					pick_ok_q <= 1'b0;
					slot_ok_q <= 1'b0;
					st_q <= ST_NULL;
					addr_q <= '0;
					bytes_q <= '0;
				end
				S_FIT: if (!prime_q) begin
					if (fits && better) begin
						pick_ok_q <= 1'b1;
						pick_q <= rd_idx_q;
						pick_start_q <= rd_start_s1;
						pick_size_q <= rd_size_s1;
					end
					if (!rd_valid && !slot_ok_q) begin
						slot_ok_q <= 1'b1;
						slot_q <= rd_idx_q;
					end
				end
				S_APPLY: if (pick_ok_q) begin
					free_q[pick_q] <= 1'b0;
					st_q <= ST_OK;
					addr_q <= pick_start_q + Hdr;
					if (split_c) begin
						valid_q[slot_q] <= 1'b1;
						free_q[slot_q] <= 1'b1;
						bytes_q <= need_q;
						in_use_q <= in_use_q + need_q;
					end else begin
						bytes_q <= pick_size_q;
						in_use_q <= in_use_q + pick_size_q;
					end
				end
				S_GROW: begin
					if (heap_top_q + grow_c > HeapLim) begin
						st_q <= ST_OOM;
					end else if (!slot_ok_q) begin
						st_q <= ST_FULL;
					end else begin
						valid_q[slot_q] <= 1'b1;
						free_q[slot_q] <= 1'b0;
						heap_top_q <= heap_top_q + grow_c;
						in_use_q <= in_use_q + grow_c;
						st_q <= ST_OK;
						addr_q <= heap_top_q + Hdr;
						bytes_q <= grow_c;
					end
				end
				S_FIND: if (!prime_q && rd_valid && rd_start_s1 + Hdr == ua_q) begin
					pick_ok_q <= 1'b1;
					k_q <= rd_idx_q;
					k_start_q <= rd_start_s1;
					k_size_q <= rd_size_s1;
				end
				S_FREE: begin
					idx_q <= '0;
					prime_q <= 1'b1;
					if (!pick_ok_q) begin
						st_q <= ST_INVALID;
					end else if (free_q[k_q]) begin
						st_q <= ST_DOUBLE;
					end else begin
						st_q <= ST_OK;
						bytes_q <= k_size_q;
						in_use_q <= (in_use_q >= k_size_q) ? in_use_q - k_size_q : '0;
						free_q[k_q] <= 1'b1;
					end
					pick_ok_q <= 1'b0;
				end
				S_RIGHT, S_LEFT: if (!prime_q && !pick_ok_q && nb_hit) begin
					pick_ok_q <= 1'b1;
					nb_q <= rd_idx_q;
					nb_size_q <= rd_size_s1;
				end
				S_RMERGE: begin
					if (pick_ok_q) begin
						k_size_q <= k_size_q + nb_size_q;
						valid_q[nb_q] <= 1'b0;
						free_q[nb_q] <= 1'b0;
					end
					pick_ok_q <= 1'b0;
					idx_q <= '0;
					prime_q <= 1'b1;
				end
				S_LMERGE: if (pick_ok_q) begin
					valid_q[k_q] <= 1'b0;
					free_q[k_q] <= 1'b0;
				end
				S_DONE: if (done_load) begin
					peak_q <= peak_n;
					m_data_q <= {2'd0, peak_n[SizeW-1:0], in_use_q[SizeW-1:0],
						bytes_q[SizeW-1:0], addr_q[AddrW-1:0], st_q};
				end
				default: ;
			endcase
		end
	end

	`ASSERT_IMP(a_ready_idle, clk, arst_n, s_tready, state_q == S_IDLE)
	`ASSERT_NXT(a_done_valid, clk, arst_n, state_q == S_DONE, m_tvalid)
	`ASSERT_IMP(a_peak_ge, clk, arst_n, m_tvalid, m_tdata[85:65] >= m_tdata[64:44])
	`ASSERT_IMP(a_ok_addr, clk, arst_n, m_tvalid && m_tdata[2:0] != ST_OK, m_tdata[22:3] == '0)
	`ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`ASSERT_IMP(a_heap_lim, clk, arst_n, 1'b1, heap_top_q <= HeapLim)

endmodule
